// ===== design/assert_macros.svh =====
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/gto_pkg.sv =====
package gto_pkg;

  localparam int GLYPH_COLUMNS = 5;
  localparam int FONT_ENTRIES  = 128;
  localparam int ROM_ROWS      = 128;
  localparam int ROM_COLS      = 5;
  localparam int POS_BEATS     = 3;

  localparam int ROW_W  = $clog2(ROM_ROWS);
  localparam int COL_W  = $clog2(GLYPH_COLUMNS + 1);
  localparam int GLYPH_LIMIT = (FONT_ENTRIES < ROM_ROWS) ? FONT_ENTRIES : ROM_ROWS;

  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] CTRL_DATA    = 8'h40;
  localparam logic [7:0] CTRL_CMD_V1  = 8'h80;
  localparam logic [7:0] CTRL_CMD_V2  = 8'h00;
  localparam logic [7:0] CMD_PAGE     = 8'hb0;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic [3:0] NIBBLE       = 4'hf;

  localparam logic [1:0] VARIANT_NONE = 2'd0;
  localparam logic [1:0] VARIANT_V1   = 2'd1;

  localparam logic [1:0] REG_INVERT  = 2'd0;
  localparam logic [1:0] REG_VARIANT = 2'd1;
  localparam logic [1:0] REG_DEVADDR = 2'd2;

  typedef enum logic {
    REQ_PRINT    = 1'b0,
    REQ_POSITION = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    BEAT_GLYPH  = 2'd0,
    BEAT_SPACER = 2'd1,
    BEAT_CMD    = 2'd2
  } beat_kind_t;

  typedef logic [ROM_COLS*8-1:0] font_row_t;

  // One beat headed for the output, built by the sequencer.
  typedef struct packed {
    beat_kind_t       kind;
    logic [COL_W-1:0] col;
    logic             glyph_ok;
    logic [7:0]       ctrl;
    logic [7:0]       cmd;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic busy;
    logic fire;
    logic last;
  } seq_stat_t;

  // Column 0 sits in the most significant byte.
  localparam font_row_t FONT_ROM [ROM_ROWS] = '{
    40'h0000000000, 40'h00004F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0102040000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h064949493F,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C0418047C, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0201020402, 40'h3E55554122,
    40'h0000000000, 40'h0000790000, 40'h1824742E24, 40'h487E494240,
    40'h5D2222225D, 40'h15167C1615, 40'h0000770000, 40'h0A55555528,
    40'h0001000100, 40'h000A0D0A04, 40'h08142A1422, 40'h040404041C,
    40'h0008080800, 40'h0101010101, 40'h0002050200, 40'h44445F4444,
    40'h0000040201, 40'h7E2020103E, 40'h060F7F007F, 40'h0018180000,
    40'h0040502000, 40'h000A0D0A00, 40'h22142A1408, 40'h1708342A7D,
    40'h1708046A59, 40'h3048454020, 40'h0808080808, 40'h7E08080808,
    40'h7E7E080808, 40'h7E7E7E0808, 40'h7E7E7E7E08, 40'h7E7E7E7E7E
  };

endpackage

// ===== design/gto_font_rom.sv =====
module gto_font_rom (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gto_pkg::ROW_W-1:0]   addr,
  output gto_pkg::font_row_t          row
);
  import gto_pkg::*;

  // Synchronous read; hold the word while the next stage is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      row <= FONT_ROM[addr];
    end
  end

endmodule

// ===== design/gto_seq.sv =====
module gto_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [7:0]                 char_code,
  input  logic [2:0]                 page_row,
  input  logic [3:0]                 text_column,
  input  logic [1:0]                 display_variant,
  input  logic                       take,
  output logic [gto_pkg::ROW_W-1:0]  rom_addr,
  output gto_pkg::beat_t             beat,
  output gto_pkg::seq_stat_t         stat
);
  import gto_pkg::*;

  logic             busy;
  req_t             cur_type;
  logic [7:0]       cur_code;
  logic [2:0]       cur_row;
  logic [3:0]       cur_tcol;
  logic [COL_W-1:0] cnt;

  logic       fire;
  logic       last;
  logic       in_fire;
  logic [7:0] idx;
  logic [8:0] idx_ext;
  logic [6:0] pix;

  assign fire     = busy && take;
  assign in_ready = !busy || (fire && last);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_fire) begin
      // drop requests while no display is fitted
      busy <= (display_variant != VARIANT_NONE);
    end else if (fire && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_type <= req_t'(req_type);
      cur_code <= char_code;
      cur_row  <= page_row;
      cur_tcol <= text_column;
      cnt      <= '0;
    end else if (fire) begin
      cnt <= cnt + COL_W'(1);
    end
  end

  assign idx      = cur_code - FIRST_CODE;
  assign idx_ext  = {1'b0, idx};
  assign rom_addr = idx[ROW_W-1:0];
  assign pix      = {cur_tcol, 3'b000};

  always_comb begin
    beat          = '0;
    beat.glyph_ok = (cur_code >= FIRST_CODE) && (idx_ext < 9'(GLYPH_LIMIT));
    beat.col      = cnt;
    last          = 1'b0;
    unique case (cur_type)
      REQ_PRINT: begin
        beat.ctrl = CTRL_DATA;
        if (cnt == COL_W'(GLYPH_COLUMNS)) begin
          beat.kind = BEAT_SPACER;
          last      = 1'b1;
        end else begin
          beat.kind = BEAT_GLYPH;
        end
      end
      REQ_POSITION: begin
        beat.kind = BEAT_CMD;
        beat.ctrl = (display_variant == VARIANT_V1) ? CTRL_CMD_V1 : CTRL_CMD_V2;
        priority if (cnt == COL_W'(0)) begin
          beat.cmd = CMD_PAGE + {5'b00000, cur_row};
        end else if (cnt == COL_W'(1)) begin
          beat.cmd = {4'h0, pix[3:0] & NIBBLE};
        end else begin
          beat.cmd = CMD_COL_HIGH + {4'h0, {1'b0, pix[6:4]} & NIBBLE};
        end
        last = (cnt == COL_W'(POS_BEATS - 1));
      end
      default: begin
        beat.kind = BEAT_CMD;
      end
    endcase
    beat.last = last;
  end

  assign stat.busy = busy;
  assign stat.fire = fire;
  assign stat.last = last;

endmodule

// ===== design/gto_emit.sv =====
module gto_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          invert_mask,
  input  logic [6:0]          device_address,
  input  logic                fire,
  input  gto_pkg::beat_t      beat,
  input  gto_pkg::font_row_t  row,
  output logic                take,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          bus_address,
  output logic [7:0]          control_byte,
  output logic [7:0]          payload_byte,
  output logic                last_of_run
);
  import gto_pkg::*;

  logic  b_valid;
  beat_t b_beat;
  logic  c_en;
  logic [7:0] col_byte;
  logic [7:0] byte_next;

  assign c_en = !out_valid || out_ready;
  assign take = !b_valid || c_en;

  // Stage B runs in step with the ROM read register.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (take) begin
      b_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_beat <= beat;
    end
  end

  always_comb begin
    col_byte = '0;
    for (int i = 0; i < ROM_COLS; i++) begin
      if (b_beat.col == COL_W'(i)) begin
        col_byte = row[(ROM_COLS-1-i)*8 +: 8];
      end
    end
    if (!b_beat.glyph_ok) begin
      col_byte = '0;
    end
  end

  always_comb begin
    unique case (b_beat.kind)
      BEAT_GLYPH:  byte_next = col_byte ^ invert_mask;
      BEAT_SPACER: byte_next = invert_mask;
      BEAT_CMD:    byte_next = b_beat.cmd;
      default:     byte_next = b_beat.cmd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en && b_valid) begin
      bus_address  <= device_address;
      control_byte <= b_beat.ctrl;
      payload_byte <= byte_next;
      last_of_run  <= b_beat.last;
    end
  end

endmodule

// ===== design/glyph_text_to_oled_stream.sv =====
// Display request to OLED write stream.
// Input channel (in_valid/in_ready): one request per beat. req_type 0 prints
// char_code as five glyph columns XORed with invert_mask plus one spacer
// column; req_type 1 sets the write position from page_row and text_column.
// Output channel (out_valid/out_ready): one bus write per beat with
// bus_address, control_byte, payload_byte; last_of_run marks the final write
// of a request. A print gives 6 beats, a position request 3.
// Pipeline: each beat is registered in stage B with the ROM read, then in the
// output register. Throughput: one beat per cycle while out_ready does not
// stall the output; the sequencer issues one font ROM read per beat, and the
// next request is accepted on the cycle its predecessor issues its last beat.
// With display_variant 0 requests are accepted and produce no writes.
// Configuration through the APB port (invert_mask at 0x0, display_variant at
// 0x4, device_address at 0x8); write only while the block is idle.
// Reset clears the configuration registers and the valid flags, emptying the pipeline.
// When out_ready is low the output register holds, the ROM stage and the
// sequencer stall behind it, and in_ready drops once the sequencer is busy.
`include "assert_macros.svh"

module glyph_text_to_oled_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  char_code,
  input  logic [2:0]  page_row,
  input  logic [3:0]  text_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  bus_address,
  output logic [7:0]  control_byte,
  output logic [7:0]  payload_byte,
  output logic        last_of_run
);
  import gto_pkg::*;

  logic [7:0] invert_mask;
  logic [1:0] display_variant;
  logic [6:0] device_address;
  logic       wr_en;

  logic             take;
  logic [ROW_W-1:0] rom_addr;
  beat_t            beat;
  seq_stat_t        stat;
  font_row_t        row;

  logic in_fire;
  logic drop_req;
  logic spacer_beat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_mask     <= '0;
      display_variant <= '0;
      device_address  <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_INVERT:  invert_mask     <= pwdata[7:0];
        REG_VARIANT: display_variant <= pwdata[1:0];
        REG_DEVADDR: device_address  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INVERT:  prdata = {24'h0, invert_mask};
      REG_VARIANT: prdata = {30'h0, display_variant};
      REG_DEVADDR: prdata = {25'h0, device_address};
      default:     prdata = '0;
    endcase
  end

  gto_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .char_code       (char_code),
    .page_row        (page_row),
    .text_column     (text_column),
    .display_variant (display_variant),
    .take            (take),
    .rom_addr        (rom_addr),
    .beat            (beat),
    .stat            (stat)
  );

  gto_font_rom u_rom (
    .clk  (clk),
    .en   (take),
    .addr (rom_addr),
    .row  (row)
  );

  gto_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .invert_mask    (invert_mask),
    .device_address (device_address),
    .fire           (stat.fire),
    .beat           (beat),
    .row            (row),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .bus_address    (bus_address),
    .control_byte   (control_byte),
    .payload_byte   (payload_byte),
    .last_of_run    (last_of_run)
  );

  assign in_fire     = in_valid && in_ready;
  assign drop_req    = in_fire && (display_variant == VARIANT_NONE);
  assign spacer_beat = out_valid && last_of_run && (control_byte == CTRL_DATA);

  `ASSERT_NOW(a_accept_when_free, clk, rst, in_fire, !stat.busy || (stat.fire && stat.last))
  `ASSERT_NEXT(a_no_display_drop, clk, rst, drop_req, !stat.busy)
  `ASSERT_NOW(a_spacer_is_mask, clk, rst, spacer_beat, payload_byte == invert_mask)

endmodule
